// ===== rtl/assert_macros.svh =====
// assertion macros used by slot_timer_bank
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
else $error("assertion failed");
`endif

// ===== rtl/stb_pkg.sv =====
// types and codes for the slot timer bank
// no dependencies
`default_nettype none
package stb_pkg;
	typedef enum logic [3:0] {
		REQ_ADD = 4'd0, REQ_CANCEL = 4'd1, REQ_PAUSE = 4'd2, REQ_RESUME = 4'd3,
		REQ_QUERY = 4'd4, REQ_TICK = 4'd5, REQ_CLEAR = 4'd6, REQ_ACTIVATE = 4'd7,
		REQ_SUSPEND = 4'd8
	} req_t;
	typedef enum logic [2:0] {
		RES_DONE = 3'd0, RES_ADDED = 3'd1, RES_FIRED = 3'd2, RES_RELEASED = 3'd3,
		RES_REFUSED = 3'd4
	} res_t;
	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_SCAN_RD, ST_SCAN_EX, ST_FLUSH
	} state_t;
	// controller to datapath
	typedef struct packed {
		logic latch;
		logic rd_handle;
		logic exec;
		logic scan_rd;
		logic scan_ex;
		logic scan_init;
		logic flush;
	} cmd_t;
	// datapath to controller
	typedef struct packed {
		logic scan_req;
		logic scan_end;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/slot_timer_bank.sv =====
// top level of the slot timer bank: controller plus datapath
// depends on stb_pkg, stb_ctrl, stb_datapath, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// usage:
//   a request is taken when start is high and busy is low; its fields are
//   sampled at that edge.
//   each result appears for one cycle with done high; last marks the final
//   result of the request. the receiver cannot stall the block.
//   add, cancel, pause, resume, query, activate, suspend and unknown
//   requests, and tick or clear with nothing to walk, pass through the read
//   and exec states and give one result, registered in exec; the next
//   request can be taken while that result is shown. tick with live timers
//   and clear with used timers walk all slots, each slot through a scan read
//   and a scan exec state on the single-port stores, then a flush state;
//   one result per fired or released timer trails the slot that caused it.
//   reset clears all masks, the time and generations; stores need no
//   clearing pass.
//   a tick that fires nothing but had live timers gives one done result.
module slot_timer_bank #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 48,
	parameter int TAG_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [3:0] req_type,
	input wire logic [3:0] handle_slot,
	input wire logic [31:0] handle_generation,
	input wire logic [31:0] duration,
	input wire logic repeat_flag,
	input wire logic [31:0] user_data,
	input wire logic [19:0] elapsed,
	output logic done,
	output logic [2:0] result_kind,
	output logic [3:0] out_slot,
	output logic [31:0] out_generation,
	output logic [31:0] out_data,
	output logic also_released,
	output logic is_active,
	output logic last
);
	stb_pkg::cmd_t cmd;
	stb_pkg::stat_t stat;
	logic rv;

	stb_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .busy(busy),
		.cmd(cmd));
	stb_datapath #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .handle_slot(handle_slot),
		.handle_generation(handle_generation), .duration(duration),
		.repeat_flag(repeat_flag), .user_data(user_data), .elapsed(elapsed),
		.result_valid(rv), .result_kind(result_kind), .out_slot(out_slot),
		.out_generation(out_generation), .out_data(out_data),
		.also_released(also_released), .is_active(is_active), .last(last));

	assign done = rv;

	`ASSERT_IMPLIES(a_busy_start, clk, arst_n, start && !busy, cmd.latch)
	`ASSERT_NEXT(a_latch_busy, clk, arst_n, cmd.latch, busy)
endmodule
`default_nettype wire

// ===== rtl/stb_ram.sv =====
// generic single-port ram, registered read
// no dependencies
`default_nettype none
module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/stb_ctrl.sv =====
// controller for the slot timer bank
// depends on stb_pkg
`default_nettype none
module stb_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire stb_pkg::stat_t stat,
	output logic busy,
	output stb_pkg::cmd_t cmd
);
	stb_pkg::state_t state_q, state_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= stb_pkg::ST_IDLE;
		else state_q <= state_d;
	end
	always_comb begin
		state_d = state_q;
		case (state_q)
			stb_pkg::ST_IDLE: if (start) state_d = stb_pkg::ST_READ;
			stb_pkg::ST_READ: state_d = stb_pkg::ST_EXEC;
			stb_pkg::ST_EXEC: state_d = stat.scan_req ? stb_pkg::ST_SCAN_RD : stb_pkg::ST_IDLE;
			stb_pkg::ST_SCAN_RD: state_d = stb_pkg::ST_SCAN_EX;
			stb_pkg::ST_SCAN_EX: state_d = stat.scan_end ? stb_pkg::ST_FLUSH : stb_pkg::ST_SCAN_RD;
			stb_pkg::ST_FLUSH: state_d = stb_pkg::ST_IDLE;
			default: state_d = stb_pkg::ST_IDLE;
		endcase
	end
	always_comb begin
		cmd = '0;
		busy = (state_q != stb_pkg::ST_IDLE);
		case (state_q)
			stb_pkg::ST_IDLE: cmd.latch = start;
			stb_pkg::ST_READ: cmd.rd_handle = 1'b1;
			stb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.scan_init = stat.scan_req;
			end
			stb_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
			stb_pkg::ST_SCAN_EX: cmd.scan_ex = 1'b1;
			stb_pkg::ST_FLUSH: cmd.flush = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/stb_datapath.sv =====
// datapath: masks, time, per-slot stores and result register
// depends on stb_pkg and stb_ram
`default_nettype none
module stb_datapath #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 48,
	parameter int TAG_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire stb_pkg::cmd_t cmd,
	output stb_pkg::stat_t stat,
	input wire logic [3:0] req_type,
	input wire logic [3:0] handle_slot,
	input wire logic [31:0] handle_generation,
	input wire logic [31:0] duration,
	input wire logic repeat_flag,
	input wire logic [31:0] user_data,
	input wire logic [19:0] elapsed,
	output logic result_valid,
	output logic [2:0] result_kind,
	output logic [3:0] out_slot,
	output logic [31:0] out_generation,
	output logic [31:0] out_data,
	output logic also_released,
	output logic is_active,
	output logic last
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	logic [3:0] req_q, hslot_q;
	logic [31:0] hgen_q, dur_q;
	logic rep_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [19:0] el_q;
	logic [SLOTS-1:0] used_q, live_q, held_q, rep_mask_q, gen_nz_q, scan_set_q;
	logic running_q;
	logic [TIME_BITS-1:0] now_q;
	logic [SW-1:0] idx_q;

	logic [SW-1:0] addr;
	logic dl_we, pr_we, tg_we, gn_we;
	logic [TIME_BITS-1:0] dl_w, dl_r;
	logic [31:0] pr_r, gn_w, gn_r;
	logic [TAG_BITS-1:0] tg_r;

	stb_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_dl (.clk(clk), .we(dl_we), .addr(addr),
		.wdata(dl_w), .rdata(dl_r));
	stb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_pr (.clk(clk), .we(pr_we), .addr(addr),
		.wdata(dur_q), .rdata(pr_r));
	stb_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tg (.clk(clk), .we(tg_we), .addr(addr),
		.wdata(tag_q), .rdata(tg_r));
	stb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_gn (.clk(clk), .we(gn_we), .addr(addr),
		.wdata(gn_w), .rdata(gn_r));

	// lowest free slot
	logic [SLOTS-1:0] freem;
	logic [SW-1:0] free_idx;
	logic any_free;
	always_comb begin
		freem = ~used_q;
		any_free = |freem;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (freem[i]) free_idx = SW'(i);
	end

	logic hslot_ok;
	logic [SW-1:0] hidx;
	logic [31:0] gen_cur;
	logic handle_ok;
	assign hslot_ok = ({28'd0, hslot_q} < 32'(SLOTS));
	assign hidx = hslot_q[SW-1:0];
	assign gen_cur = gen_nz_q[hidx] ? gn_r : 32'd0;
	assign handle_ok = hslot_ok && used_q[hidx] && (gen_cur == hgen_q);

	logic [TIME_BITS:0] add_now_dur, add_dl_now, add_now_pr;
	logic [TIME_BITS-1:0] now_el;
	logic [TIME_BITS:0] now_el_w;
	assign add_now_dur = {1'b0, now_q} + {{(TIME_BITS-31){1'b0}}, dur_q};
	assign add_dl_now = {1'b0, dl_r} + {1'b0, now_q};
	assign add_now_pr = {1'b0, now_q} + {{(TIME_BITS-31){1'b0}}, pr_r};
	assign now_el_w = {1'b0, now_q} + {{(TIME_BITS-19){1'b0}}, el_q};
	assign now_el = now_el_w[TIME_BITS] ? TMAX : now_el_w[TIME_BITS-1:0];

	logic is_scan;
	assign is_scan = (req_q == stb_pkg::REQ_TICK && (|live_q)) ||
		(req_q == stb_pkg::REQ_CLEAR && (|used_q));
	assign stat.scan_req = is_scan;
	assign stat.scan_end = (32'(idx_q) == 32'(SLOTS - 1));

	logic fire_now;
	logic scan_hit;
	assign fire_now = live_q[idx_q] && now_q >= dl_r;
	assign scan_hit = (req_q == stb_pkg::REQ_TICK) ? fire_now : scan_set_q[idx_q];

	// scan results are held back by one hit so the final one can carry last
	logic pend_q;
	logic [2:0] pend_kind_q;
	logic [3:0] pend_slot_q;
	logic [31:0] pend_data_q;
	logic pend_rel_q;

	// ram address and writes
	always_comb begin
		addr = hidx;
		dl_we = 1'b0; pr_we = 1'b0; tg_we = 1'b0; gn_we = 1'b0;
		dl_w = '0;
		gn_w = gen_cur + 32'd1;
		if (cmd.latch) addr = handle_slot[SW-1:0];
		else if (cmd.rd_handle) addr = (req_q == stb_pkg::REQ_ADD) ? free_idx : hidx;
		else if (cmd.scan_rd || cmd.scan_ex) addr = idx_q;
		else if (cmd.exec && req_q == stb_pkg::REQ_ADD) addr = free_idx;
		if (cmd.exec) begin
			case (req_q)
				stb_pkg::REQ_ADD: if (any_free) begin
					gn_w = (gen_nz_q[free_idx] ? gn_r : 32'd0) + 32'd1;
					gn_we = 1'b1; tg_we = 1'b1; pr_we = 1'b1; dl_we = 1'b1;
					dl_w = add_now_dur[TIME_BITS] ? TMAX : add_now_dur[TIME_BITS-1:0];
				end
				stb_pkg::REQ_PAUSE: if (handle_ok && !held_q[hidx]) begin
					dl_we = 1'b1;
					dl_w = (dl_r > now_q) ? dl_r - now_q : '0;
				end
				stb_pkg::REQ_RESUME: if (handle_ok && held_q[hidx]) begin
					dl_we = 1'b1;
					dl_w = add_dl_now[TIME_BITS] ? TMAX : add_dl_now[TIME_BITS-1:0];
				end
				default: ;
			endcase
		end
		if (cmd.scan_ex && req_q == stb_pkg::REQ_TICK && live_q[idx_q] &&
				now_q >= dl_r && rep_mask_q[idx_q]) begin
			dl_we = 1'b1;
			dl_w = add_now_pr[TIME_BITS] ? TMAX : add_now_pr[TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			hslot_q <= handle_slot;
			hgen_q <= handle_generation;
			dur_q <= duration;
			rep_q <= repeat_flag;
			tag_q <= user_data[TAG_BITS-1:0];
			el_q <= elapsed;
		end
		if (cmd.exec) begin
			result_kind <= stb_pkg::RES_DONE;
			out_slot <= '0;
			out_generation <= '0;
			out_data <= '0;
			also_released <= 1'b0;
			is_active <= 1'b0;
			last <= 1'b1;
			case (req_q)
				stb_pkg::REQ_ADD: begin
					if (any_free) begin
						result_kind <= stb_pkg::RES_ADDED;
						out_slot <= 4'(free_idx);
						out_generation <= gn_w;
					end else result_kind <= stb_pkg::RES_REFUSED;
				end
				stb_pkg::REQ_CANCEL: if (handle_ok) begin
					result_kind <= stb_pkg::RES_RELEASED;
					out_slot <= hslot_q;
					out_data <= 32'(tg_r);
				end
				stb_pkg::REQ_QUERY: is_active <= handle_ok;
				default: ;
			endcase
		end
		if (cmd.scan_ex && scan_hit) begin
			pend_kind_q <= (req_q == stb_pkg::REQ_TICK) ? stb_pkg::RES_FIRED
				: stb_pkg::RES_RELEASED;
			pend_slot_q <= 4'(idx_q);
			pend_data_q <= 32'(tg_r);
			pend_rel_q <= (req_q == stb_pkg::REQ_TICK) && !rep_mask_q[idx_q];
			if (pend_q) begin
				result_kind <= pend_kind_q;
				out_slot <= pend_slot_q;
				out_generation <= '0;
				out_data <= pend_data_q;
				also_released <= pend_rel_q;
				is_active <= 1'b0;
				last <= 1'b0;
			end
		end
		if (cmd.flush) begin
			result_kind <= pend_q ? pend_kind_q : stb_pkg::RES_DONE;
			out_slot <= pend_q ? pend_slot_q : 4'd0;
			out_generation <= '0;
			out_data <= pend_q ? pend_data_q : 32'd0;
			also_released <= pend_q && pend_rel_q;
			is_active <= 1'b0;
			last <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; live_q <= '0; held_q <= '0; rep_mask_q <= '0;
			gen_nz_q <= '0; running_q <= 1'b0; now_q <= '0;
			idx_q <= '0; scan_set_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (cmd.exec && !is_scan) || (cmd.scan_ex && scan_hit && pend_q) ||
				cmd.flush;
			if (cmd.exec) begin
				idx_q <= '0;
				case (req_q)
					stb_pkg::REQ_ADD: if (any_free) begin
						used_q[free_idx] <= 1'b1;
						held_q[free_idx] <= 1'b0;
						rep_mask_q[free_idx] <= rep_q;
						live_q[free_idx] <= running_q;
						gen_nz_q[free_idx] <= 1'b1;
					end
					stb_pkg::REQ_CANCEL: if (handle_ok) begin
						used_q[hidx] <= 1'b0; live_q[hidx] <= 1'b0;
						held_q[hidx] <= 1'b0; rep_mask_q[hidx] <= 1'b0;
					end
					stb_pkg::REQ_PAUSE: if (handle_ok && !held_q[hidx]) begin
						live_q[hidx] <= 1'b0; held_q[hidx] <= 1'b1;
					end
					stb_pkg::REQ_RESUME: if (handle_ok && held_q[hidx]) begin
						held_q[hidx] <= 1'b0;
						if (running_q) live_q[hidx] <= 1'b1;
					end
					stb_pkg::REQ_TICK: if (|live_q) now_q <= now_el;
					stb_pkg::REQ_CLEAR: begin
						scan_set_q <= used_q;
						used_q <= '0; live_q <= '0; held_q <= '0; rep_mask_q <= '0;
					end
					stb_pkg::REQ_ACTIVATE: begin
						running_q <= 1'b1;
						live_q <= used_q & ~held_q;
					end
					stb_pkg::REQ_SUSPEND: begin
						running_q <= 1'b0;
						live_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.scan_ex) begin
				if (req_q == stb_pkg::REQ_TICK && fire_now && !rep_mask_q[idx_q]) begin
					used_q[idx_q] <= 1'b0; live_q[idx_q] <= 1'b0;
					held_q[idx_q] <= 1'b0; rep_mask_q[idx_q] <= 1'b0;
				end
				if (!stat.scan_end) idx_q <= idx_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (cmd.scan_init || cmd.flush) pend_q <= 1'b0;
		else if (cmd.scan_ex && scan_hit) pend_q <= 1'b1;
	end
endmodule
`default_nettype wire
